/* hw/rtl/dcul_pkg.sv */
// Shared widths, constants and unit status type for the duty-cycle usage limiter.
`timescale 1ns / 1ps

package dcul_pkg;

  localparam int USAGE_W     = 24;
  localparam int LOAD_W      = 24;
  localparam int JIT_W       = 10;
  localparam int RATIO_W     = 32;
  localparam int TIME_W      = 29;
  localparam int CFG_W       = 24;
  localparam int CORE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USAGE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT  = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_MAX = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0]  TIME_MAX  = 29'h1FFF_FFFF;

  localparam int BASE_SLOT_US = 100000;
  localparam int SLOT_FRAC    = 8;     // slot held in Q19.8 microseconds

  localparam logic [JIT_W-1:0] JIT_MOD = 10'd1001;
  localparam int JIT_BASE      = 9500;
  // slot_q8 * scale / 2560 is done as a shift by 9 and a divide by 5
  localparam int NS_SHIFT      = 9;
  localparam int NS_DIV        = 5;
  localparam int SMOOTH_DIV    = 10;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* hw/rtl/duty_cycle_usage_limiter.sv */
// Top level of the duty-cycle usage limiter: sequencer, state and output register.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata: usage, load, jitter; in_tuser: flags
//  out_    | out | out_tvalid / out_tready| out_tdata: work, sleep, duty ratio, resume
//  cfg_    | in  | cfg_we                 | cfg_index, cfg_wdata (usage limit, core count)
//
// One beat at a time goes through a bit-serial multiplier and a restoring divider,
// one bit per cycle each.
// A register write reloads the duty ratio through the divider, during which no beat
// is taken. No clearing pass after reset.
// A result waits in the output register; the next beat is taken meanwhile.
`timescale 1ns / 1ps

module duty_cycle_usage_limiter
  import dcul_pkg::*;
#(
  parameter int MIN_SLOT_US   = 100000,
  parameter int MAX_SLOT_US   = 500000,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [23:0] usage_q16, [47:24] load_q16, [57:48] jitter, [63:58] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] usage_valid, [1] load_ready
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [28:0] work_ns, [57:29] sleep_ns, [89:58] duty_ratio_q32,
  // [90] resume, [95:91] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int     LIM_W     = CORE_W + FRACTION_BITS;
  localparam int     LIMR_W    = CFG_W + 1;
  localparam longint SLOT_LO   = longint'(MIN_SLOT_US) << SLOT_FRAC;
  localparam longint SLOT_HI   = longint'(MAX_SLOT_US) << SLOT_FRAC;
  localparam longint SLOT_BASE = longint'(BASE_SLOT_US) << SLOT_FRAC;
  localparam longint SLOT_MAX  = (SLOT_HI > SLOT_BASE) ? SLOT_HI : SLOT_BASE;
  localparam int     SLOT_W    = $clog2(SLOT_MAX + 1);
  localparam int     S10_W     = SLOT_W + 4;
  localparam int     NS_W      = SLOT_W + 3;
  localparam int     NSD_W     = SLOT_W + 5;
  localparam int     LD_W      = S10_W + LOAD_W - FRACTION_BITS;
  localparam int     CL_W      = LIM_W + RATIO_W - FRACTION_BITS;
  localparam int     MA_W      = (LIM_W > S10_W) ? LIM_W : S10_W;
  localparam int     PW        = MA_W + RATIO_W;
  localparam int     DV_A      = (CL_W > RATIO_W) ? CL_W : RATIO_W;
  localparam int     DV_B      = (LD_W > NSD_W) ? LD_W : NSD_W;
  localparam int     DV_W      = (DV_A > DV_B) ? DV_A : DV_B;
  localparam int     DS_W      = USAGE_W;
  localparam int     DCNT_W    = $clog2(DV_W + 1);
  localparam int     TW        = (NS_W > TIME_W) ? NS_W : TIME_W;
  localparam int     CW        = (LIM_W > LIMR_W) ? LIM_W : LIMR_W;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_R_MUL   = 5'd1;
  localparam logic [4:0] ST_R_MUL_W = 5'd2;
  localparam logic [4:0] ST_R_DIV   = 5'd3;
  localparam logic [4:0] ST_R_DIV_W = 5'd4;
  localparam logic [4:0] ST_L_CHK   = 5'd5;
  localparam logic [4:0] ST_L_MUL   = 5'd6;
  localparam logic [4:0] ST_L_MUL_W = 5'd7;
  localparam logic [4:0] ST_L_DIV   = 5'd8;
  localparam logic [4:0] ST_L_DIV_W = 5'd9;
  localparam logic [4:0] ST_S_DIV   = 5'd10;
  localparam logic [4:0] ST_S_DIV_W = 5'd11;
  localparam logic [4:0] ST_N_MUL   = 5'd12;
  localparam logic [4:0] ST_N_MUL_W = 5'd13;
  localparam logic [4:0] ST_N_DIV   = 5'd14;
  localparam logic [4:0] ST_N_DIV_W = 5'd15;
  localparam logic [4:0] ST_W_MUL   = 5'd16;
  localparam logic [4:0] ST_W_MUL_W = 5'd17;
  localparam logic [4:0] ST_OUT     = 5'd18;
  localparam logic [4:0] ST_C_DIV   = 5'd19;
  localparam logic [4:0] ST_C_DIV_W = 5'd20;

  // control state
  logic [4:0]         state_r, state_nxt;
  logic [RATIO_W-1:0] duty_r, duty_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               started_r, started_nxt;
  logic               susp_r, susp_nxt;
  logic [LIMR_W-1:0]  lim_r, lim_nxt;
  logic [CORE_W-1:0]  cores_r, cores_nxt;
  logic               out_valid_r, out_valid_nxt;

  // beat payload and intermediates
  logic [USAGE_W-1:0] u_r, u_nxt;
  logic               lr_r, lr_nxt;
  logic [LOAD_W-1:0]  ld_r, ld_nxt;
  logic [JIT_W-1:0]   jit_r, jit_nxt;
  logic [SLOT_W-1:0]  nw_r, nw_nxt;
  logic [NS_W-1:0]    sns_r, sns_nxt;
  logic [TIME_W-1:0]  out_work_r, out_work_nxt;
  logic [TIME_W-1:0]  out_sleep_r, out_sleep_nxt;
  logic [RATIO_W-1:0] out_ratio_r, out_ratio_nxt;
  logic               out_resume_r, out_resume_nxt;

  // arithmetic units
  logic               mul_start;
  logic [MA_W-1:0]    mul_a;
  logic [RATIO_W-1:0] mul_b;
  logic [PW-1:0]      mul_prod;
  unit_stat_t         mul_st;
  logic               div_start;
  logic [DV_W-1:0]    div_num;
  logic [DS_W-1:0]    div_den;
  logic [DS_W-1:0]    div_rem;
  logic [DCNT_W-1:0]  div_steps;
  logic [DV_W-1:0]    div_quo;
  unit_stat_t         div_st;

  // derived values
  logic [CORE_W-1:0]  cores_eff;
  logic [LIM_W-1:0]   lim_top;
  logic [CW-1:0]      lim_sel;
  logic [LIM_W-1:0]   eff_lim;
  logic [USAGE_W-1:0] u_eff;
  logic [MA_W-1:0]    prod_hi;
  logic [CORE_W+1:0]  cores_x3;
  logic [JIT_W-1:0]   jit_in;
  logic [DV_W-1:0]    nw_lo, nw_hi;
  logic [NS_W-1:0]    wk_raw, wk_min, wk, sns_m1, sl;
  logic               mul_fin, div_fin;

  dcul_mul #(
    .A_W (MA_W),
    .B_W (RATIO_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_st)
  );

  dcul_div #(
    .N_W (DV_W),
    .D_W (DS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .rem_init (div_rem),
    .steps    (div_steps),
    .quo      (div_quo),
    .stat     (div_st)
  );

  assign mul_fin = mul_st.done && !mul_st.busy;
  assign div_fin = div_st.done && !div_st.busy;

  // effective limit: clamped to [1 LSB, cores << F]
  assign cores_eff = (cores_r == '0) ? CORE_W'(1) : cores_r;
  assign lim_top   = LIM_W'(cores_eff) << FRACTION_BITS;
  always_comb begin
    lim_sel = (CW'(lim_r) > CW'(lim_top)) ? CW'(lim_top) : CW'(lim_r);
    if (lim_sel == '0) begin
      lim_sel = CW'(1);
    end
  end
  assign eff_lim  = LIM_W'(lim_sel);
  assign u_eff    = (u_r == '0) ? USAGE_W'(1) : u_r;
  assign prod_hi  = mul_prod[PW-1:RATIO_W];
  assign cores_x3 = ({2'b00, cores_eff} << 1) + {2'b00, cores_eff};
  assign jit_in   = in_tdata[57:48];
  assign nw_lo    = (div_quo < DV_W'(SLOT_LO)) ? DV_W'(SLOT_LO) : div_quo;
  assign nw_hi    = (nw_lo > DV_W'(SLOT_HI)) ? DV_W'(SLOT_HI) : nw_lo;

  // work = slot_ns * ratio >> 32, kept in [1, slot_ns - 1]
  assign wk_raw = prod_hi[NS_W-1:0];
  assign wk_min = (wk_raw == '0) ? NS_W'(1) : wk_raw;
  assign sns_m1 = sns_r - NS_W'(1);
  assign wk     = (wk_min > sns_m1) ? sns_m1 : wk_min;
  assign sl     = sns_r - wk;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    duty_nxt       = duty_r;
    slot_nxt       = slot_r;
    started_nxt    = started_r;
    susp_nxt       = susp_r;
    lim_nxt        = lim_r;
    cores_nxt      = cores_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    u_nxt          = u_r;
    lr_nxt         = lr_r;
    ld_nxt         = ld_r;
    jit_nxt        = jit_r;
    nw_nxt         = nw_r;
    sns_nxt        = sns_r;
    out_work_nxt   = out_work_r;
    out_sleep_nxt  = out_sleep_r;
    out_ratio_nxt  = out_ratio_r;
    out_resume_nxt = out_resume_r;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    div_rem        = '0;
    div_steps      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          lr_nxt    = in_tuser[1];
          u_nxt     = in_tdata[23:0];
          ld_nxt    = in_tdata[47:24];
          jit_nxt   = (jit_in >= JIT_MOD) ? (jit_in - JIT_MOD) : jit_in;
          state_nxt = in_tuser[0] ? ST_R_MUL : ST_L_CHK;
        end
      end
      ST_R_MUL: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(eff_lim);
        mul_b     = duty_r;
        state_nxt = ST_R_MUL_W;
      end
      ST_R_MUL_W: begin
        if (mul_fin) begin
          state_nxt = ST_R_DIV;
        end
      end
      ST_R_DIV: begin
        // quotient of 2^32 or more saturates; otherwise upper half seeds remainder
        if (prod_hi >= MA_W'(u_eff)) begin
          duty_nxt  = RATIO_MAX;
          state_nxt = ST_L_CHK;
        end else begin
          div_start = 1'b1;
          div_num   = DV_W'(mul_prod[RATIO_W-1:0]) << (DV_W - RATIO_W);
          div_den   = u_eff;
          div_rem   = prod_hi[DS_W-1:0];
          div_steps = DCNT_W'(RATIO_W);
          state_nxt = ST_R_DIV_W;
        end
      end
      ST_R_DIV_W: begin
        if (div_fin) begin
          duty_nxt  = (div_quo[RATIO_W-1:0] == '0) ? RATIO_W'(1) : div_quo[RATIO_W-1:0];
          state_nxt = ST_L_CHK;
        end
      end
      ST_L_CHK: begin
        if (!started_r) begin
          started_nxt = 1'b1;
          state_nxt   = ST_N_MUL;
        end else if (lr_r) begin
          state_nxt = ST_L_MUL;
        end else begin
          state_nxt = ST_N_MUL;
        end
      end
      ST_L_MUL: begin
        mul_start = 1'b1;
        mul_a     = (MA_W'(slot_r) << 3) + (MA_W'(slot_r) << 1);
        mul_b     = RATIO_W'(ld_r);
        state_nxt = ST_L_MUL_W;
      end
      ST_L_MUL_W: begin
        if (mul_fin) begin
          state_nxt = ST_L_DIV;
        end
      end
      ST_L_DIV: begin
        // x / (3c << F) == (x >> F) / 3c
        div_start = 1'b1;
        div_num   = DV_W'(mul_prod[FRACTION_BITS +: LD_W]) << (DV_W - LD_W);
        div_den   = DS_W'(cores_x3);
        div_steps = DCNT_W'(LD_W);
        state_nxt = ST_L_DIV_W;
      end
      ST_L_DIV_W: begin
        if (div_fin) begin
          nw_nxt    = SLOT_W'(nw_hi);
          state_nxt = ST_S_DIV;
        end
      end
      ST_S_DIV: begin
        div_start = 1'b1;
        div_num   = DV_W'((S10_W'(slot_r) << 2) + (S10_W'(slot_r) << 1)
                          + (S10_W'(nw_r) << 2)) << (DV_W - S10_W);
        div_den   = DS_W'(SMOOTH_DIV);
        div_steps = DCNT_W'(S10_W);
        state_nxt = ST_S_DIV_W;
      end
      ST_S_DIV_W: begin
        if (div_fin) begin
          slot_nxt  = SLOT_W'(div_quo);
          state_nxt = ST_N_MUL;
        end
      end
      ST_N_MUL: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(slot_r);
        mul_b     = RATIO_W'(JIT_BASE) + RATIO_W'(jit_r);
        state_nxt = ST_N_MUL_W;
      end
      ST_N_MUL_W: begin
        if (mul_fin) begin
          state_nxt = ST_N_DIV;
        end
      end
      ST_N_DIV: begin
        div_start = 1'b1;
        div_num   = DV_W'(mul_prod[NS_SHIFT +: NSD_W]) << (DV_W - NSD_W);
        div_den   = DS_W'(NS_DIV);
        div_steps = DCNT_W'(NSD_W);
        state_nxt = ST_N_DIV_W;
      end
      ST_N_DIV_W: begin
        if (div_fin) begin
          // tiny slot raised to 2 ns so work and sleep are both non-zero
          sns_nxt   = (div_quo < DV_W'(2)) ? NS_W'(2) : div_quo[NS_W-1:0];
          state_nxt = ST_W_MUL;
        end
      end
      ST_W_MUL: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(sns_r);
        mul_b     = duty_r;
        state_nxt = ST_W_MUL_W;
      end
      ST_W_MUL_W: begin
        if (mul_fin) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_work_nxt   = (TW'(wk) > TW'(TIME_MAX)) ? TIME_MAX : TIME_W'(wk);
          out_sleep_nxt  = (TW'(sl) > TW'(TIME_MAX)) ? TIME_MAX : TIME_W'(sl);
          out_ratio_nxt  = duty_r;
          out_resume_nxt = susp_r;
          susp_nxt       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_C_DIV: begin
        div_start = 1'b1;
        div_num   = DV_W'({eff_lim, {(RATIO_W - FRACTION_BITS){1'b0}}}) << (DV_W - CL_W);
        div_den   = DS_W'(cores_eff);
        div_steps = DCNT_W'(CL_W);
        state_nxt = ST_C_DIV_W;
      end
      ST_C_DIV_W: begin
        if (div_fin) begin
          if (div_quo > DV_W'(RATIO_MAX)) begin
            duty_nxt = RATIO_MAX;
          end else if (div_quo == '0) begin
            duty_nxt = RATIO_W'(1);
          end else begin
            duty_nxt = div_quo[RATIO_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // every write reloads the ratio; a write during a reload restarts it
    if (cfg_we) begin
      case (cfg_index)
        REG_USAGE_LIMIT: begin
          lim_nxt   = {1'b0, cfg_wdata};
          state_nxt = ST_C_DIV;
        end
        REG_CORE_COUNT: begin
          cores_nxt = cfg_wdata[CORE_W-1:0];
          state_nxt = ST_C_DIV;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      duty_r      <= RATIO_MAX;
      slot_r      <= SLOT_W'(SLOT_BASE);
      started_r   <= 1'b0;
      susp_r      <= 1'b0;
      lim_r       <= LIMR_W'(1) << FRACTION_BITS;
      cores_r     <= CORE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      duty_r      <= duty_nxt;
      slot_r      <= slot_nxt;
      started_r   <= started_nxt;
      susp_r      <= susp_nxt;
      lim_r       <= lim_nxt;
      cores_r     <= cores_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r          <= u_nxt;
    lr_r         <= lr_nxt;
    ld_r         <= ld_nxt;
    jit_r        <= jit_nxt;
    nw_r         <= nw_nxt;
    sns_r        <= sns_nxt;
    out_work_r   <= out_work_nxt;
    out_sleep_r  <= out_sleep_nxt;
    out_ratio_r  <= out_ratio_nxt;
    out_resume_r <= out_resume_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_resume_r, out_ratio_r, out_sleep_r, out_work_r};

endmodule

/* hw/rtl/dcul_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module dcul_mul
  import dcul_pkg::*;
#(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] prod,
  output unit_stat_t       stat
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_r;
  logic [A_W-1:0]   hi_r, hi_nxt;
  logic [B_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [A_W:0]     sum;

  // partial sum only spans the multiplicand; product shifts down into lo_r
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : {(A_W + 1){1'b0}});

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt  = '0;
      lo_nxt  = b;
      cnt_nxt = CNT_W'(B_W);
    end else if (cnt_r != '0) begin
      hi_nxt   = sum[A_W:1];
      lo_nxt   = {sum[0], lo_r[B_W-1:1]};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign prod      = {hi_r, lo_r};
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

/* hw/rtl/dcul_div.sv */
// Restoring divider, one quotient bit per cycle, dividend given left aligned.
`timescale 1ns / 1ps

module dcul_div
  import dcul_pkg::*;
#(
  parameter int N_W = 48,
  parameter int D_W = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [N_W-1:0]             num,
  input  logic [D_W-1:0]             den,
  input  logic [D_W-1:0]             rem_init,
  input  logic [$clog2(N_W+1)-1:0]   steps,
  output logic [N_W-1:0]             quo,
  output unit_stat_t                 stat
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   num_r, num_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W-1:0]   den_r;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [D_W:0]     trial, diff;
  logic             ge;

  // remainder stays below the divisor, so the trial value needs one extra bit
  assign trial = {rem_r, num_r[N_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      quo_nxt = '0;
      rem_nxt = rem_init;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      num_nxt  = {num_r[N_W-2:0], 1'b0};
      quo_nxt  = {quo_r[N_W-2:0], ge};
      rem_nxt  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

/* bench/duty_cycle_usage_limiter_test.sv */
// Self-checking bench for the duty-cycle usage limiter: directed and random beats, predicted splits.
`timescale 1ns / 1ps

module duty_cycle_usage_limiter_test
  import dcul_pkg::*;
();

  localparam int FRAC          = 16;
  localparam int SLOT_MIN_US   = 100000;
  localparam int SLOT_MAX_US   = 500000;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int BEATS_PER_PH  = 314;
  localparam int TAIL_CYCLES   = 400;
  localparam int CFG_SETTLE    = 64;

  typedef struct packed {
    logic              usage_valid;
    logic [USAGE_W-1:0] usage;
    logic              load_ready;
    logic [LOAD_W-1:0] load;
    logic [JIT_W-1:0]  jitter;
  } sample_t;

  typedef struct packed {
    logic               resume;
    logic [RATIO_W-1:0] ratio;
    logic [TIME_W-1:0]  sleep_ns;
    logic [TIME_W-1:0]  work_ns;
  } split_t;

  // Tracks limiter state and the work/sleep splits still owed by the block
  class slot_split_tracker;
    logic [63:0] limit_reg;
    logic [63:0] cores_reg;
    logic [63:0] ratio;
    logic [63:0] slot_q8;
    bit          started;
    bit          suspended;
    split_t      pending_splits[$];
    int          mismatches;

    function new();
      limit_reg = 64'd1 << FRAC;
      cores_reg = 64'd1;
      slot_q8 = 64'(BASE_SLOT_US) << SLOT_FRAC;
      started = 0;
      suspended = 0;
      mismatches = 0;
      reload_ratio();
    endfunction

    function logic [63:0] cores();
      return (cores_reg == 0) ? 64'd1 : cores_reg;
    endfunction

    function logic [63:0] limit();
      logic [63:0] v;
      v = limit_reg;
      if (v > (cores() << FRAC)) v = cores() << FRAC;
      if (v < 1) v = 1;
      return v;
    endfunction

    function logic [63:0] clamp_ratio(logic [63:0] r);
      if (r < 1) return 64'd1;
      if (r > 64'(RATIO_MAX)) return 64'(RATIO_MAX);
      return r;
    endfunction

    function void reload_ratio();
      ratio = clamp_ratio((limit() << (32 - FRAC)) / cores());
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_USAGE_LIMIT) limit_reg = 64'(val);
      else cores_reg = 64'(val[CORE_W-1:0]);
      reload_ratio();
    endfunction

    function void take_sample(sample_t s);
      logic [63:0] u, nw, lo, hi, jit, slot_ns, work, sleep_v;
      split_t r;
      if (s.usage_valid) begin
        u = (s.usage == 0) ? 64'd1 : 64'(s.usage);
        ratio = clamp_ratio(ratio * limit() / u);
      end
      if (!started) begin
        started = 1;     // load on the opening cycle is dropped
      end else if (s.load_ready) begin
        lo = 64'(SLOT_MIN_US) << SLOT_FRAC;
        hi = 64'(SLOT_MAX_US) << SLOT_FRAC;
        nw = slot_q8 * 64'(s.load) * 10 / ((64'd3 * cores()) << FRAC);
        if (nw < lo) nw = lo;
        if (nw > hi) nw = hi;
        slot_q8 = (6 * slot_q8 + 4 * nw) / 10;
      end
      jit = 64'(s.jitter) % 64'(JIT_MOD);
      slot_ns = slot_q8 * (64'(JIT_BASE) + jit) / 2560;
      if (slot_ns < 2) slot_ns = 2;
      work = (slot_ns * ratio) >> 32;
      if (work < 1) work = 1;
      if (work > slot_ns - 1) work = slot_ns - 1;
      sleep_v = slot_ns - work;
      if (work > 64'(TIME_MAX)) work = 64'(TIME_MAX);
      if (sleep_v > 64'(TIME_MAX)) sleep_v = 64'(TIME_MAX);
      r.work_ns = work[TIME_W-1:0];
      r.sleep_ns = sleep_v[TIME_W-1:0];
      r.ratio = ratio[RATIO_W-1:0];
      r.resume = suspended;
      pending_splits.push_back(r);
      suspended = 1;
    endfunction

    function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_split(logic [OUT_TDATA_W-1:0] d);
      split_t e;
      if (pending_splits.size() == 0) begin
        $error("result beat with nothing outstanding: %h", d);
        mismatches++;
        return;
      end
      e = pending_splits.pop_front();
      compare("work_ns", 64'(e.work_ns), 64'(d[28:0]));
      compare("sleep_ns", 64'(e.sleep_ns), 64'(d[57:29]));
      compare("duty_ratio_q32", 64'(e.ratio), 64'(d[89:58]));
      compare("resume", 64'(e.resume), 64'(d[90]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  slot_split_tracker tracker = new();
  int cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req = 0;
  int hold_left = 0;

  duty_cycle_usage_limiter #(
    .MIN_SLOT_US  (SLOT_MIN_US),
    .MAX_SLOT_US  (SLOT_MAX_US),
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (out_tvalid && out_tready) tracker.match_split(out_tdata);
    end
  end

  function automatic sample_t mk(bit uv, logic [23:0] u, bit lr, logic [23:0] l,
                                 logic [9:0] j);
    sample_t s;
    s.usage_valid = uv;
    s.usage = u;
    s.load_ready = lr;
    s.load = l;
    s.jitter = j;
    return s;
  endfunction

  // mostly usage near the limit and load near the slot's balance point
  function automatic sample_t random_sample();
    sample_t s;
    logic [63:0] v;
    int pick;
    s.usage_valid = ($urandom_range(0, 99) < 80);
    pick = $urandom_range(0, 9);
    if (pick == 0) v = 0;
    else if (pick == 1) v = 64'($urandom_range(0, 24'hFFFFFF));
    else if (pick == 2) v = 64'hFFFFFF;
    else v = tracker.limit() * $urandom_range(50, 200) / 100 + $urandom_range(0, 255);
    if (v > 64'hFFFFFF) v = 64'hFFFFFF;
    s.usage = v[23:0];
    s.load_ready = ($urandom_range(0, 99) < 40);
    if ($urandom_range(0, 3) == 0) v = 64'($urandom_range(0, 24'hFFFFFF));
    else v = tracker.cores() * $urandom_range(10000, 120000);
    if (v > 64'hFFFFFF) v = 64'hFFFFFF;
    s.load = v[23:0];
    s.jitter = 10'($urandom_range(0, 1023));
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, s.jitter, s.load, s.usage};
    in_tuser <= {s.load_ready, s.usage_valid};
    do @(posedge clk); while (!in_tready);
    tracker.take_sample(s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_splits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    // block may still be reloading the ratio from an earlier write
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    send_idle_pct = 16;
    recv_idle_pct = 51;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // opening cycle with a load sample that must be ignored
    send_sample(mk(1, 24'h010000, 1, 24'hFFFFFF, 10'd0));
    send_sample(mk(0, 24'hABCDEF, 1, 24'h000000, 10'd1000));
    send_sample(mk(1, 24'h000000, 0, 24'h5A5A5A, 10'd1023));
    send_sample(mk(1, 24'hFFFFFF, 1, 24'hFFFFFF, 10'd1001));
    send_sample(mk(1, 24'h020000, 1, 24'h00CCCC, 10'd0));
    send_sample(mk(1, 24'h008000, 0, 24'h000000, 10'd500));
    send_sample(mk(1, 24'h000001, 1, 24'h004CCD, 10'd1));
    send_sample(mk(0, 24'h000000, 1, 24'h010000, 10'd999));
    send_sample(mk(1, 24'hFFFFFF, 0, 24'hFFFFFF, 10'd1002));
    send_sample(mk(1, 24'hFFFFFF, 0, 24'h000000, 10'd3));
    send_sample(mk(1, 24'hFFFFFF, 1, 24'h800000, 10'd1022));
    send_sample(mk(1, 24'hFFFFFF, 1, 24'h7FFFFF, 10'd512));
    send_sample(mk(1, 24'h000001, 1, 24'h000001, 10'd255));
    send_sample(mk(1, 24'h00FFFF, 0, 24'h123456, 10'd768));

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) drain();
      case (ph / 2)
        0: begin send_idle_pct = 16; recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        1: begin
          write_reg(REG_USAGE_LIMIT, 24'hFFFFFF);
          write_reg(REG_CORE_COUNT, 24'd255);
        end
        2: begin
          write_reg(REG_CORE_COUNT, 24'd0);
          write_reg(REG_USAGE_LIMIT, 24'd0);
        end
        3, 4: begin
          write_reg(REG_CORE_COUNT, 24'($urandom_range(1, 255)));
          write_reg(REG_USAGE_LIMIT, 24'($urandom_range(1, 24'hFFFFFF)));
        end
        5: begin
          write_reg(REG_USAGE_LIMIT, 24'd1);
          write_reg(REG_CORE_COUNT, 24'd1);
        end
        default: ;
      endcase
      if (ph == 4) hold_req = 1;
      repeat (BEATS_PER_PH) send_sample(random_sample());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_splits.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dcul_pkg.sv
hw/rtl/dcul_mul.sv
hw/rtl/dcul_div.sv
hw/rtl/duty_cycle_usage_limiter.sv
bench/duty_cycle_usage_limiter_test.sv
